// ===== rtl/ucbas_pkg.sv =====
// ----------------------------------------------------------------------------
// ucbas_pkg
// Shared types and constants of the UCB1 arm selector: beat payloads,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package ucbas_pkg;

    localparam int GAIN_W = 12;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd384;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    typedef struct packed {
        logic [2:0] style;
        logic       feedback_like;
        logic       prev_contour_valid;
        logic [2:0] prev_contour_arm;
        logic       prev_rhythm_valid;
        logic [2:0] prev_rhythm_arm;
    } t_in_item;

    typedef struct packed {
        logic [2:0] contour_arm;
        logic [2:0] rhythm_arm;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CRD_RD,
        S_CRD_WAIT,
        S_SCAN_RD,
        S_SCAN_ACC,
        S_SCAN_END,
        S_NORM,
        S_LOG,
        S_LN,
        S_ARM_RD,
        S_ARM_WAIT,
        S_DIV,
        S_SQ_LD,
        S_SQRT,
        S_MUL,
        S_CMP,
        S_PICK_RD,
        S_PICK_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        A_PREV,
        A_ARM,
        A_BEST
    } t_addr_sel;

    typedef enum logic {
        W_CREDIT,
        W_PICK
    } t_wr_sel;

    typedef struct packed {
        logic      load_in;
        logic      bank_clr;
        logic      bank_inc;
        t_addr_sel addr_sel;
        logic      mem_wr;
        t_wr_sel   wr_sel;
        logic      arm_clr;
        logic      arm_inc;
        logic      scan_clr;
        logic      scan_acc;
        logic      norm_load;
        logic      norm_step;
        logic      log_load;
        logic      log_step;
        logic      ln_calc;
        logic      div_load;
        logic      div_step;
        logic      sqrt_load;
        logic      sqrt_step;
        logic      mul_calc;
        logic      cmp_calc;
        logic      res_store;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic cred_go;
        logic hv_nz;
        logic found;
        logic arm_last;
        logic norm_done;
        logic cnt_last;
        logic bank;
    } t_stat;

endpackage

// ===== rtl/ucbas_if.sv =====
// ----------------------------------------------------------------------------
// ucbas_if
// Valid/ready channels of the UCB1 arm selector, one for items in and one
// for picks out.
// ----------------------------------------------------------------------------
interface ucbas_in_if import ucbas_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ucbas_out_if import ucbas_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ucbas_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucbas_ctrl
// Sequencer of the arm selector: credit, scan, log, per-arm score and pick
// for each bank in turn, plus the output holding flag.
// ----------------------------------------------------------------------------
module ucbas_ctrl import ucbas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;
    logic   out_free;

    assign out_free    = !r_out_full || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    always_comb begin
        n_out_full = r_out_full;
        if (r_out_full && i_out_ready) begin
            n_out_full = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_full = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CRD_RD;
            end
            S_CRD_RD: begin
                n_state = i_stat.cred_go ? S_CRD_WAIT : S_SCAN_RD;
            end
            S_CRD_WAIT:  n_state = S_SCAN_RD;
            S_SCAN_RD:   n_state = S_SCAN_ACC;
            S_SCAN_ACC: begin
                n_state = i_stat.arm_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END: begin
                n_state = i_stat.found ? S_PICK_RD : S_NORM;
            end
            S_NORM: begin
                if (i_stat.norm_done) n_state = S_LOG;
            end
            S_LOG: begin
                if (i_stat.cnt_last) n_state = S_LN;
            end
            S_LN:       n_state = S_ARM_RD;
            S_ARM_RD:   n_state = S_ARM_WAIT;
            S_ARM_WAIT: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.cnt_last) n_state = S_SQ_LD;
            end
            S_SQ_LD:    n_state = S_SQRT;
            S_SQRT: begin
                if (i_stat.cnt_last) n_state = S_MUL;
            end
            S_MUL:      n_state = S_CMP;
            S_CMP: begin
                n_state = i_stat.arm_last ? S_PICK_RD : S_ARM_RD;
            end
            S_PICK_RD:  n_state = S_PICK_WAIT;
            S_PICK_WAIT: begin
                n_state = i_stat.bank ? S_DONE : S_CRD_RD;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = A_ARM;
        o_cmd.wr_sel   = W_CREDIT;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in  = i_in_valid;
                o_cmd.bank_clr = i_in_valid;
            end
            S_CRD_RD: begin
                o_cmd.addr_sel = A_PREV;
                o_cmd.arm_clr  = !i_stat.cred_go;
                o_cmd.scan_clr = !i_stat.cred_go;
            end
            S_CRD_WAIT: begin
                o_cmd.addr_sel = A_PREV;
                o_cmd.mem_wr   = i_stat.hv_nz;
                o_cmd.arm_clr  = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            S_SCAN_RD: begin
                o_cmd.addr_sel = A_ARM;
            end
            S_SCAN_ACC: begin
                o_cmd.scan_acc = 1'b1;
                o_cmd.arm_inc  = !i_stat.arm_last;
            end
            S_SCAN_END: begin
                o_cmd.norm_load = !i_stat.found;
            end
            S_NORM: begin
                o_cmd.norm_step = !i_stat.norm_done;
                o_cmd.log_load  = i_stat.norm_done;
            end
            S_LOG: begin
                o_cmd.log_step = 1'b1;
            end
            S_LN: begin
                o_cmd.ln_calc = 1'b1;
                o_cmd.arm_clr = 1'b1;
            end
            S_ARM_RD: begin
                o_cmd.addr_sel = A_ARM;
            end
            S_ARM_WAIT: begin
                o_cmd.div_load = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_SQ_LD: begin
                o_cmd.sqrt_load = 1'b1;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul_calc = 1'b1;
            end
            S_CMP: begin
                o_cmd.cmp_calc = 1'b1;
                o_cmd.arm_inc  = !i_stat.arm_last;
            end
            S_PICK_RD: begin
                o_cmd.addr_sel = A_BEST;
            end
            S_PICK_WAIT: begin
                o_cmd.addr_sel  = A_BEST;
                o_cmd.wr_sel    = W_PICK;
                o_cmd.mem_wr    = 1'b1;
                o_cmd.res_store = 1'b1;
                o_cmd.bank_inc  = !i_stat.bank;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.addr_sel = A_ARM;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CRD_RD))
        else $error("accepted item did not start the credit step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_full && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result finished over an untaken beat");

    a_wr_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_wr |=> !o_cmd.mem_wr)
        else $error("back to back store writes");

endmodule

// ===== rtl/ucbas_dp.sv =====
// ----------------------------------------------------------------------------
// ucbas_dp
// Datapath of the arm selector: count store, scan accumulator, iterative
// log2, two shared restoring dividers, bit-serial square root and scorer.
// ----------------------------------------------------------------------------
module ucbas_dp import ucbas_pkg::*; #(
    parameter int NUM_ARMS    = 8,
    parameter int NUM_STYLES  = 6,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  t_in_item          i_item,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata,
    output t_out_item         o_result
);

    localparam int DEPTH = NUM_STYLES * NUM_ARMS;
    localparam int MAW   = $clog2(2 * DEPTH);
    localparam int RW    = COUNT_WIDTH;
    localparam int HW    = COUNT_WIDTH + 1;
    localparam int AW    = $clog2(NUM_ARMS);
    localparam int TW    = HW + AW;
    localparam int KW    = $clog2(TW);
    localparam int L2W   = KW + 16;
    localparam int QNW   = L2W + 1;
    localparam int MNW   = RW + 17;
    localparam int DNW   = (MNW > QNW) ? MNW : QNW;
    localparam int VW    = DNW + 16;
    localparam int SQN   = (VW + 1) / 2;
    localparam int SW    = SQN;
    localparam int PW    = GAIN_W + SW;
    localparam int SCW   = ((DNW > PW - 8) ? DNW : PW - 8) + 1;
    localparam int CNTW  = $clog2(((DNW > SQN) ? DNW : SQN) + 1);
    localparam logic [VW-1:0] SQ_BIT0 = VW'(1) << (2 * (SQN - 1));

    // store and item
    logic [RW+HW-1:0] mem [2*DEPTH];
    logic [2*DEPTH-1:0] r_vld;
    logic [RW+HW-1:0] r_rd;
    logic             r_rd_vld;
    logic [RW-1:0]    rd_rew;
    logic [HW-1:0]    rd_hv;
    logic [MAW-1:0]   addr;
    logic [MAW-1:0]   arm_src;
    logic [RW+HW-1:0] wdata;
    t_in_item         r_item;
    logic [MAW-1:0]   r_base;
    logic [2:0]       style_eff;
    logic             r_bank;
    logic [GAIN_W-1:0] r_gain;

    // scan and pick
    logic [AW-1:0]  r_arm;
    logic [AW-1:0]  r_best;
    logic           r_found;
    logic [TW-1:0]  r_total;
    logic [2:0]     r_pick_c, r_pick_r, r_out_c, r_out_r;

    // log
    logic [TW-1:0]  r_tn;
    logic [KW-1:0]  r_k;
    logic [30:0]    r_y;
    logic [15:0]    r_frac;
    logic [L2W-1:0] r_lnq;
    logic [TW+30:0] ext;
    logic [61:0]    sq;
    logic [31:0]    y2;
    logic [L2W-1:0] l2m;
    logic [L2W+15:0] lnp;

    // divide, root, score
    logic [CNTW-1:0] r_cnt;
    logic [HW-1:0]   r_dvs;
    logic [DNW-1:0]  r_num_m, r_num_q;
    logic [HW-1:0]   r_rem_m, r_rem_q;
    logic [HW:0]     sh_m, sh_q, df_m, df_q;
    logic            ge_m, ge_q;
    logic [VW-1:0]   r_v, r_res, r_bit, sq_t;
    logic            ge_s;
    logic [PW-1:0]   r_prod;
    logic [SCW-1:0]  r_bscore, score;
    logic [HW:0]     hv_add;
    logic [RW-1:0]   rew_n;
    logic [HW-1:0]   hv_n;
    logic            prev_ok_c, prev_ok_r;

    assign style_eff = (int'(i_item.style) >= NUM_STYLES) ? 3'd0 : i_item.style;

    always_comb begin
        case (i_cmd.addr_sel)
            A_PREV:  arm_src = r_bank ? MAW'(r_item.prev_rhythm_arm)
                                      : MAW'(r_item.prev_contour_arm);
            A_ARM:   arm_src = MAW'(r_arm);
            A_BEST:  arm_src = MAW'(r_best);
            default: arm_src = MAW'(r_arm);
        endcase
    end

    assign addr = (r_bank ? MAW'(DEPTH) : MAW'(0)) + r_base + arm_src;

    assign rd_rew = r_rd_vld ? r_rd[RW+HW-1:HW] : '0;
    assign rd_hv  = r_rd_vld ? r_rd[HW-1:0] : '0;

    // saturating updates
    always_comb begin
        rew_n = rd_rew;
        if (i_cmd.wr_sel == W_CREDIT) begin
            hv_add = {1'b0, rd_hv} + (HW+1)'(2);
            if (r_item.feedback_like && rd_rew != '1) begin
                rew_n = rd_rew + 1'b1;
            end
        end else begin
            hv_add = {1'b0, rd_hv} + (HW+1)'(1);
        end
        hv_n  = hv_add[HW] ? '1 : hv_add[HW-1:0];
        wdata = {rew_n, hv_n};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        r_rd <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_bank   <= 1'b0;
            r_gain   <= GAIN_RESET;
        end else begin
            if (i_cmd.mem_wr) begin
                r_vld[addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[addr];
            if (i_cmd.bank_clr) begin
                r_bank <= 1'b0;
            end else if (i_cmd.bank_inc) begin
                r_bank <= 1'b1;
            end
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
        end
    end

    assign prev_ok_c = r_item.prev_contour_valid && (int'(r_item.prev_contour_arm) < NUM_ARMS);
    assign prev_ok_r = r_item.prev_rhythm_valid && (int'(r_item.prev_rhythm_arm) < NUM_ARMS);

    // log2 squaring step and ln scaling
    assign ext = {r_tn, 31'b0};
    assign sq  = 62'(r_y) * 62'(r_y);
    assign y2  = sq[61:30];
    assign l2m = {r_k, r_frac} - L2W'(65536);
    assign lnp = (L2W+16)'(l2m) * (L2W+16)'(LN2_Q16);

    // restoring divide, one quotient bit per beat of the counter
    assign sh_m = {r_rem_m, r_num_m[DNW-1]};
    assign sh_q = {r_rem_q, r_num_q[DNW-1]};
    assign ge_m = sh_m >= {1'b0, r_dvs};
    assign ge_q = sh_q >= {1'b0, r_dvs};
    assign df_m = sh_m - {1'b0, r_dvs};
    assign df_q = sh_q - {1'b0, r_dvs};

    assign sq_t = r_res + r_bit;
    assign ge_s = r_v >= sq_t;

    assign score = SCW'(r_num_m) + SCW'(r_prod >> 8);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
            r_base <= MAW'(style_eff) * MAW'(NUM_ARMS);
        end
        if (i_cmd.arm_clr) begin
            r_arm <= '0;
        end else if (i_cmd.arm_inc) begin
            r_arm <= r_arm + 1'b1;
        end
        if (i_cmd.scan_clr) begin
            r_total <= '0;
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.scan_acc) begin
            r_total <= r_total + TW'(rd_hv);
            if (rd_hv == '0 && !r_found) begin
                r_found <= 1'b1;
                r_best  <= r_arm;
            end
        end else if (i_cmd.cmp_calc) begin
            if (r_arm == '0 || score > r_bscore) begin
                r_bscore <= score;
                r_best   <= r_arm;
            end
        end
        if (i_cmd.norm_load) begin
            r_tn <= r_total;
            r_k  <= KW'(TW - 1);
        end else if (i_cmd.norm_step) begin
            r_tn <= r_tn << 1;
            r_k  <= r_k - 1'b1;
        end
        if (i_cmd.log_load) begin
            r_y    <= ext[TW+30 -: 31];
            r_frac <= '0;
            r_cnt  <= CNTW'(16);
        end else if (i_cmd.log_step) begin
            r_cnt <= r_cnt - 1'b1;
            if (y2[31]) begin
                r_y    <= y2[31:1];
                r_frac <= {r_frac[14:0], 1'b1};
            end else begin
                r_y    <= y2[30:0];
                r_frac <= {r_frac[14:0], 1'b0};
            end
        end else if (i_cmd.div_load) begin
            r_cnt   <= CNTW'(DNW);
            r_dvs   <= rd_hv;
            r_num_m <= DNW'({rd_rew, 17'b0});
            r_num_q <= DNW'({r_lnq, 1'b0});
            r_rem_m <= '0;
            r_rem_q <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt   <= r_cnt - 1'b1;
            r_num_m <= {r_num_m[DNW-2:0], ge_m};
            r_num_q <= {r_num_q[DNW-2:0], ge_q};
            r_rem_m <= ge_m ? df_m[HW-1:0] : sh_m[HW-1:0];
            r_rem_q <= ge_q ? df_q[HW-1:0] : sh_q[HW-1:0];
        end else if (i_cmd.sqrt_load) begin
            r_cnt <= CNTW'(SQN);
            r_v   <= {r_num_q, 16'b0};
            r_res <= '0;
            r_bit <= SQ_BIT0;
        end else if (i_cmd.sqrt_step) begin
            r_cnt <= r_cnt - 1'b1;
            r_bit <= r_bit >> 2;
            if (ge_s) begin
                r_v   <= r_v - sq_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
        if (i_cmd.ln_calc) begin
            r_lnq <= lnp[L2W+15:16];
        end
        if (i_cmd.mul_calc) begin
            r_prod <= PW'(r_gain) * PW'(r_res[SW-1:0]);
        end
        if (i_cmd.res_store) begin
            if (r_bank) begin
                r_pick_r <= 3'(r_best);
            end else begin
                r_pick_c <= 3'(r_best);
            end
        end
        if (i_cmd.out_load) begin
            r_out_c <= r_pick_c;
            r_out_r <= r_pick_r;
        end
    end

    assign o_stat.cred_go   = r_bank ? prev_ok_r : prev_ok_c;
    assign o_stat.hv_nz     = (rd_hv != '0);
    assign o_stat.found     = r_found;
    assign o_stat.arm_last  = (r_arm == AW'(NUM_ARMS - 1));
    assign o_stat.norm_done = r_tn[TW-1] || (r_k == '0);
    assign o_stat.cnt_last  = (r_cnt == CNTW'(1));
    assign o_stat.bank      = r_bank;

    assign o_result.contour_arm = r_out_c;
    assign o_result.rhythm_arm  = r_out_r;

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.log_step || i_cmd.div_step || i_cmd.sqrt_step) |-> (r_cnt != '0))
        else $error("iteration counter stepped past zero");

endmodule

// ===== rtl/ucb1_bandit_arm_selector_core.sv =====
// ----------------------------------------------------------------------------
// ucb1_bandit_arm_selector_core
// UCB1 arm selector with contour and rhythm banks per style.
//
//   channel   dir  handshake            payload
//   i_in      in   valid/ready          style, feedback, previous picks
//   o_out     out  valid/ready          contour_arm, rhythm_arm
//   cfg       in   i_cfg_we             exploration_gain (Q4.8)
//
// one item at a time; both banks run in turn through one shared datapath.
// a bank whose style still has an unvisited arm picks the first such arm
// right after the scan; otherwise it normalizes the total, takes its log and,
// per arm, runs the restoring divide and the square root before the compare.
// synchronous reset clears the valid bits of the count store, no clear pass.
// a finished beat waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module ucb1_bandit_arm_selector_core import ucbas_pkg::*; #(
    parameter int NUM_ARMS    = 8,
    parameter int NUM_STYLES  = 6,
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata,
    ucbas_in_if.sink          i_in,
    ucbas_out_if.source       o_out
);

    t_cmd      cmd;
    t_stat     stat;
    t_out_item result;

    ucbas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ucbas_dp #(
        .NUM_ARMS    (NUM_ARMS),
        .NUM_STYLES  (NUM_STYLES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    assign o_out.data = result;

endmodule
